### rtl/core/fsa_pkg.sv
// Shared constants, codes and types for the fire spread automaton step unit.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package fsa_pkg;

    // Payload widths
    localparam int CODE_W     = 3;
    localparam int DRAW_W     = 16;
    localparam int SIZE_W     = 6;
    localparam int PCT_W      = 7;
    localparam int CNT_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Neighborhood
    localparam int NBR_NUM   = 8;
    localparam int NBR_CNT_W = 4;

    // Grid side limits
    localparam int DEF_MAX_SIZE = 32;
    localparam int MIN_SIZE     = 5;
    localparam int LIMIT_SIZE   = 62;

    // Percent scale used by both probability tests
    localparam logic [7:0] PCT_SCALE = 8'd100;

    // Cell codes
    localparam logic [CODE_W-1:0] CODE_EMPTY  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_TREE   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_FIRE   = 3'd2;
    localparam logic [CODE_W-1:0] CODE_BURN_A = 3'd3;
    localparam logic [CODE_W-1:0] CODE_BURN_B = 3'd4;
    localparam logic [CODE_W-1:0] CODE_BURN_C = 3'd5;
    localparam logic [CODE_W-1:0] CODE_BURNT  = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_P_CATCH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_P_NEIGHBOR = 2'd2;

    // Configuration reset values
    localparam logic [SIZE_W-1:0] GRID_SIZE_RST  = 6'd10;
    localparam logic [PCT_W-1:0]  P_CATCH_RST    = 7'd30;
    localparam logic [PCT_W-1:0]  P_NEIGHBOR_RST = 7'd25;

    // Neighbor slots in the window
    localparam int NB_NW = 0;
    localparam int NB_N  = 1;
    localparam int NB_NE = 2;
    localparam int NB_W  = 3;
    localparam int NB_E  = 4;
    localparam int NB_SW = 5;
    localparam int NB_S  = 6;
    localparam int NB_SE = 7;

    typedef struct packed {
        logic [CODE_W-1:0]              center;
        logic [NBR_NUM-1:0][CODE_W-1:0] nbr;
        logic [DRAW_W-1:0]              draw;
    } win_t;

    // Grid edges of the cell being evaluated, and whether it is the frame's last cell
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic frame_end;
    } meta_t;

    typedef struct packed {
        logic [CODE_W-1:0] next_code;
        logic              ignited;
        logic              burned_out;
        logic              frame_end;
        logic [CNT_W-1:0]  frame_changes;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/fsa_if.sv
// Handshake channels of the fire spread automaton step unit: cell input,
// result output and configuration write. Depends on fsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface fsa_in_if;
    logic                        valid;
    logic                        ready;
    logic [fsa_pkg::CODE_W-1:0]  cell_code;
    logic [fsa_pkg::DRAW_W-1:0]  rand_draw;

    modport source (output valid, output cell_code, output rand_draw, input ready);
    modport sink   (input valid, input cell_code, input rand_draw, output ready);
endinterface

interface fsa_out_if;
    logic                       valid;
    logic                       ready;
    logic [fsa_pkg::CODE_W-1:0] next_code;
    logic                       ignited;
    logic                       burned_out;
    logic                       frame_end;
    logic [fsa_pkg::CNT_W-1:0]  frame_changes;

    modport source (output valid, output next_code, output ignited, output burned_out,
                    output frame_end, output frame_changes, input ready);
    modport sink   (input valid, input next_code, input ignited, input burned_out,
                    input frame_end, input frame_changes, output ready);
endinterface

interface fsa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fsa_pkg::CFG_IDX_W-1:0]  index;
    logic [fsa_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/fire_spread_automaton_step_unit.sv
// Fire spread automaton step unit: one generation of a square grid streamed in raster
// order, one cell code and one random draw per item, one result per cell in raster
// order. The unit takes one item per cycle when not stalled or flushing. A cell's
// result comes out once the item holding its southeast neighbor has arrived, then
// passes both evaluation stages. After the last item of a frame the input holds off
// while the neighborhood line shifts empty slots to evaluate the bottom row; the last
// result carries frame_end and the frame's change count. The line is sized by
// MAX_SIZE; the grid side n is grid_size clamped to 5..MAX_SIZE, capped at 62.
// Writing grid_size restarts the frame. Depends on fsa_pkg, fsa_if, fsa_window, fsa_eval.
`timescale 1ns / 1ps
`default_nettype none

module fire_spread_automaton_step_unit #(
    parameter int MAX_SIZE = fsa_pkg::DEF_MAX_SIZE
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fsa_in_if.sink     cells,
    fsa_out_if.source  results,
    fsa_cfg_if.sink    cfg
);

    function automatic logic [fsa_pkg::SIZE_W-1:0] clamp_size(
        input logic [fsa_pkg::SIZE_W-1:0] req
    );
        logic [fsa_pkg::SIZE_W-1:0] hi;
        logic [fsa_pkg::SIZE_W-1:0] v;
        hi = fsa_pkg::SIZE_W'((MAX_SIZE < fsa_pkg::LIMIT_SIZE) ? MAX_SIZE
                                                                : fsa_pkg::LIMIT_SIZE);
        v  = req;
        if (v < fsa_pkg::SIZE_W'(fsa_pkg::MIN_SIZE))
        begin
            v = fsa_pkg::SIZE_W'(fsa_pkg::MIN_SIZE);
        end
        if (v > hi)
        begin
            v = hi;
        end
        return v;
    endfunction

    logic [fsa_pkg::SIZE_W-1:0] n_reg;
    logic [fsa_pkg::PCT_W-1:0]  p_catch_reg;
    logic [fsa_pkg::PCT_W-1:0]  p_nbr_reg;

    logic [fsa_pkg::SIZE_W-1:0] in_row_reg, in_row_next;
    logic [fsa_pkg::SIZE_W-1:0] in_col_reg, in_col_next;
    logic [fsa_pkg::SIZE_W-1:0] q_row_reg, q_row_next;
    logic [fsa_pkg::SIZE_W-1:0] q_col_reg, q_col_next;
    logic                       flush_reg, flush_next;
    logic                       pend_v_reg, pend_v_next;
    fsa_pkg::meta_t             pend_meta_reg, pend_meta_next;

    logic                       cfg_write;
    logic                       restart;
    logic                       win_ready;
    logic                       s0_en;
    logic                       in_fire;
    logic                       bubble;
    logic                       shift;
    logic                       emit_now;
    logic [fsa_pkg::SIZE_W-1:0] n_m1;
    logic                       in_last;
    logic                       q_last;
    logic [fsa_pkg::CODE_W-1:0] line_code;
    logic [fsa_pkg::DRAW_W-1:0] line_draw;
    fsa_pkg::win_t              win;
    fsa_pkg::result_t           res;
    logic                       res_valid;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;
    assign restart   = cfg_write && (cfg.index == fsa_pkg::REG_GRID_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg       <= clamp_size(fsa_pkg::GRID_SIZE_RST);
            p_catch_reg <= fsa_pkg::P_CATCH_RST;
            p_nbr_reg   <= fsa_pkg::P_NEIGHBOR_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg.index)
                fsa_pkg::REG_GRID_SIZE:  n_reg       <= clamp_size(cfg.data[fsa_pkg::SIZE_W-1:0]);
                fsa_pkg::REG_P_CATCH:    p_catch_reg <= cfg.data[fsa_pkg::PCT_W-1:0];
                fsa_pkg::REG_P_NEIGHBOR: p_nbr_reg   <= cfg.data[fsa_pkg::PCT_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Line advances on an accepted item, or on an empty slot while flushing
    assign s0_en       = !pend_v_reg || win_ready;
    assign cells.ready = s0_en && !flush_reg;
    assign in_fire     = cells.valid && cells.ready;
    assign bubble      = s0_en && flush_reg;
    assign shift       = in_fire || bubble;

    assign n_m1     = n_reg - fsa_pkg::SIZE_W'(1);
    assign in_last  = (in_row_reg == n_m1) && (in_col_reg == n_m1);
    assign q_last   = (q_row_reg == n_m1) && (q_col_reg == n_m1);
    // A cell is complete once its southeast neighbor enters: position n+1 onward
    assign emit_now = flush_reg || (in_row_reg > fsa_pkg::SIZE_W'(1))
                      || ((in_row_reg == fsa_pkg::SIZE_W'(1)) && (in_col_reg != '0));

    assign line_code = flush_reg ? fsa_pkg::CODE_EMPTY : cells.cell_code;
    assign line_draw = flush_reg ? '0 : cells.rand_draw;

    always_comb
    begin
        in_row_next    = in_row_reg;
        in_col_next    = in_col_reg;
        q_row_next     = q_row_reg;
        q_col_next     = q_col_reg;
        flush_next     = flush_reg;
        pend_v_next    = pend_v_reg;
        pend_meta_next = pend_meta_reg;

        if (s0_en)
        begin
            pend_v_next = shift && emit_now;
        end

        if (shift && emit_now)
        begin
            pend_meta_next.top       = (q_row_reg == '0);
            pend_meta_next.bottom    = (q_row_reg == n_m1);
            pend_meta_next.left      = (q_col_reg == '0);
            pend_meta_next.right     = (q_col_reg == n_m1);
            pend_meta_next.frame_end = q_last;
            priority if (q_last)
            begin
                q_row_next = '0;
                q_col_next = '0;
            end
            else if (q_col_reg == n_m1)
            begin
                q_col_next = '0;
                q_row_next = q_row_reg + fsa_pkg::SIZE_W'(1);
            end
            else
            begin
                q_col_next = q_col_reg + fsa_pkg::SIZE_W'(1);
            end
        end

        if (in_fire)
        begin
            priority if (in_last)
            begin
                in_row_next = '0;
                in_col_next = '0;
                flush_next  = 1'b1;
            end
            else if (in_col_reg == n_m1)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + fsa_pkg::SIZE_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + fsa_pkg::SIZE_W'(1);
            end
        end

        // Flush ends with the last cell of the frame
        if (bubble && q_last)
        begin
            flush_next = 1'b0;
        end

        if (restart)
        begin
            in_row_next = '0;
            in_col_next = '0;
            q_row_next  = '0;
            q_col_next  = '0;
            flush_next  = 1'b0;
            pend_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
            q_row_reg  <= '0;
            q_col_reg  <= '0;
            flush_reg  <= 1'b0;
            pend_v_reg <= 1'b0;
        end
        else
        begin
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
            q_row_reg  <= q_row_next;
            q_col_reg  <= q_col_next;
            flush_reg  <= flush_next;
            pend_v_reg <= pend_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_meta_reg <= pend_meta_next;
    end

    fsa_window #(
        .MAX_SIZE (MAX_SIZE)
    ) u_window (
        .clk      (clk),
        .shift    (shift),
        .n        (n_reg),
        .code_in  (line_code),
        .draw_in  (line_draw),
        .win      (win)
    );

    fsa_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .p_catch   (p_catch_reg),
        .p_nbr     (p_nbr_reg),
        .win_valid (pend_v_reg),
        .win       (win),
        .meta      (pend_meta_reg),
        .win_ready (win_ready),
        .res_valid (res_valid),
        .res_ready (results.ready),
        .res       (res)
    );

    assign results.valid         = res_valid;
    assign results.next_code     = res.next_code;
    assign results.ignited       = res.ignited;
    assign results.burned_out    = res.burned_out;
    assign results.frame_end     = res.frame_end;
    assign results.frame_changes = res.frame_changes;

endmodule

`default_nettype wire

### rtl/core/fsa_cell.sv
// One storage cell of the neighborhood line: loads from its left neighbor,
// or from a row tap when it is the entry point of a variable-length segment.
`timescale 1ns / 1ps
`default_nettype none

module fsa_cell #(
    parameter int DATA_W = fsa_pkg::CODE_W
) (
    input  wire logic              clk,
    input  wire logic              shift,
    input  wire logic              load_sel,
    input  wire logic [DATA_W-1:0] ext_in,
    input  wire logic [DATA_W-1:0] prev_in,
    output logic      [DATA_W-1:0] data_out
);

    logic [DATA_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= load_sel ? ext_in : prev_in;
        end
    end

    assign data_out = data_reg;

endmodule

`default_nettype wire

### rtl/core/fsa_window.sv
// Neighborhood line of fsa_cell instances holding two rows plus three cells of codes
// and one row plus two cells of draws. Depends on fsa_pkg and fsa_cell.
`timescale 1ns / 1ps
`default_nettype none

module fsa_window #(
    parameter int MAX_SIZE = fsa_pkg::DEF_MAX_SIZE
) (
    input  wire logic                        clk,
    input  wire logic                        shift,
    input  wire logic [fsa_pkg::SIZE_W-1:0]  n,
    input  wire logic [fsa_pkg::CODE_W-1:0]  code_in,
    input  wire logic [fsa_pkg::DRAW_W-1:0]  draw_in,
    output fsa_pkg::win_t                    win
);

    // Code line: three fixed taps, a segment, three fixed taps, a segment,
    // three fixed taps. A segment is n-3 cells long; its entry cell is set by n.
    localparam int SEG_LEN    = MAX_SIZE - 3;
    localparam int SEG_A      = 3;
    localparam int GRP_B      = SEG_A + SEG_LEN;
    localparam int SEG_B      = GRP_B + 3;
    localparam int GRP_C      = SEG_B + SEG_LEN;
    localparam int CODE_CELLS = GRP_C + 3;
    // Draw line: one fixed cell, a segment of up to MAX_SIZE, one fixed cell.
    localparam int DRAW_CELLS = MAX_SIZE + 2;

    logic [fsa_pkg::SIZE_W-1:0] entry;
    logic [fsa_pkg::CODE_W-1:0] code_q [CODE_CELLS];
    logic [fsa_pkg::DRAW_W-1:0] draw_q [DRAW_CELLS];

    assign entry = fsa_pkg::SIZE_W'(MAX_SIZE) - n;

    for (genvar k = 0; k < CODE_CELLS; k++)
    begin : g_code
        logic                       sel;
        logic [fsa_pkg::CODE_W-1:0] prev_d;
        logic [fsa_pkg::CODE_W-1:0] ext_d;

        if (k == 0)
        begin : g_head
            assign prev_d = code_in;
        end
        else
        begin : g_link
            assign prev_d = code_q[k-1];
        end

        if (k >= SEG_A && k < GRP_B)
        begin : g_seg_a
            assign sel   = (fsa_pkg::SIZE_W'(k - SEG_A) == entry);
            assign ext_d = code_q[SEG_A-1];
        end
        else if (k >= SEG_B && k < GRP_C)
        begin : g_seg_b
            assign sel   = (fsa_pkg::SIZE_W'(k - SEG_B) == entry);
            assign ext_d = code_q[SEG_B-1];
        end
        else
        begin : g_fixed
            assign sel   = 1'b0;
            assign ext_d = prev_d;
        end

        fsa_cell #(
            .DATA_W   (fsa_pkg::CODE_W)
        ) u_cell (
            .clk      (clk),
            .shift    (shift),
            .load_sel (sel),
            .ext_in   (ext_d),
            .prev_in  (prev_d),
            .data_out (code_q[k])
        );
    end

    for (genvar k = 0; k < DRAW_CELLS; k++)
    begin : g_draw
        logic                       sel;
        logic [fsa_pkg::DRAW_W-1:0] prev_d;

        if (k == 0)
        begin : g_head
            assign prev_d = draw_in;
        end
        else
        begin : g_link
            assign prev_d = draw_q[k-1];
        end

        if (k >= 1 && k <= MAX_SIZE)
        begin : g_seg
            assign sel = (fsa_pkg::SIZE_W'(k - 1) == entry);
        end
        else
        begin : g_fixed
            assign sel = 1'b0;
        end

        fsa_cell #(
            .DATA_W   (fsa_pkg::DRAW_W)
        ) u_cell (
            .clk      (clk),
            .shift    (shift),
            .load_sel (sel),
            .ext_in   (draw_q[0]),
            .prev_in  (prev_d),
            .data_out (draw_q[k])
        );
    end

    // Newest item sits at line position 0; the evaluated cell sits n+1 items behind it.
    always_comb
    begin
        win.nbr[fsa_pkg::NB_SE] = code_q[0];
        win.nbr[fsa_pkg::NB_S]  = code_q[1];
        win.nbr[fsa_pkg::NB_SW] = code_q[2];
        win.nbr[fsa_pkg::NB_E]  = code_q[GRP_B];
        win.center              = code_q[GRP_B+1];
        win.nbr[fsa_pkg::NB_W]  = code_q[GRP_B+2];
        win.nbr[fsa_pkg::NB_NE] = code_q[GRP_C];
        win.nbr[fsa_pkg::NB_N]  = code_q[GRP_C+1];
        win.nbr[fsa_pkg::NB_NW] = code_q[GRP_C+2];
        win.draw                = draw_q[DRAW_CELLS-1];
    end

endmodule

`default_nettype wire

### rtl/core/fsa_eval.sv
// Two-stage rule evaluation: edge masking and neighbor counts, then the ignition
// tests, the phase step and the frame change count. Depends on fsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fsa_eval (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       restart,
    input  wire logic [fsa_pkg::PCT_W-1:0]  p_catch,
    input  wire logic [fsa_pkg::PCT_W-1:0]  p_nbr,
    input  wire logic                       win_valid,
    input  wire fsa_pkg::win_t              win,
    input  wire fsa_pkg::meta_t             meta,
    output logic                            win_ready,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output fsa_pkg::result_t                res
);

    localparam int NB_PROD_W   = 11;
    localparam int DRAW_PROD_W = fsa_pkg::DRAW_W + 8;

    function automatic logic is_tree(input logic [fsa_pkg::CODE_W-1:0] code);
        return (code >= fsa_pkg::CODE_TREE) && (code <= fsa_pkg::CODE_BURN_C);
    endfunction

    function automatic logic is_burning(input logic [fsa_pkg::CODE_W-1:0] code);
        return (code >= fsa_pkg::CODE_FIRE) && (code <= fsa_pkg::CODE_BURN_C);
    endfunction

    // Stage 1 registers
    logic                          s1_v_reg;
    logic [fsa_pkg::CODE_W-1:0]    s1_center_reg;
    logic [fsa_pkg::NBR_CNT_W-1:0] s1_tree_reg;
    logic [fsa_pkg::NBR_CNT_W-1:0] s1_burn_reg;
    logic [fsa_pkg::DRAW_W-1:0]    s1_draw_reg;
    logic                          s1_end_reg;

    // Stage 2 registers
    logic                          res_v_reg;
    fsa_pkg::result_t              res_reg;
    logic [fsa_pkg::CNT_W-1:0]     cnt_reg;
    logic [fsa_pkg::CNT_W-1:0]     cnt_next;

    logic                          s2_en;
    logic [fsa_pkg::NBR_NUM-1:0]   nb_ok;
    logic [fsa_pkg::NBR_CNT_W-1:0] tree_sum;
    logic [fsa_pkg::NBR_CNT_W-1:0] burn_sum;

    logic [NB_PROD_W-1:0]          burn_scaled;
    logic [NB_PROD_W-1:0]          tree_scaled;
    logic [DRAW_PROD_W-1:0]        draw_scaled;
    logic [DRAW_PROD_W-1:0]        catch_scaled;
    logic                          catches;
    logic [fsa_pkg::CODE_W-1:0]    next_code;
    logic                          ign;
    logic                          burn;
    logic [fsa_pkg::CNT_W-1:0]     cnt_sum;

    assign s2_en     = !res_v_reg || res_ready;
    assign win_ready = !s1_v_reg || s2_en;

    // Drop neighbors that fall outside the grid, then count them
    always_comb
    begin
        nb_ok[fsa_pkg::NB_NW] = !meta.top && !meta.left;
        nb_ok[fsa_pkg::NB_N]  = !meta.top;
        nb_ok[fsa_pkg::NB_NE] = !meta.top && !meta.right;
        nb_ok[fsa_pkg::NB_W]  = !meta.left;
        nb_ok[fsa_pkg::NB_E]  = !meta.right;
        nb_ok[fsa_pkg::NB_SW] = !meta.bottom && !meta.left;
        nb_ok[fsa_pkg::NB_S]  = !meta.bottom;
        nb_ok[fsa_pkg::NB_SE] = !meta.bottom && !meta.right;
        tree_sum = '0;
        burn_sum = '0;
        for (int i = 0; i < fsa_pkg::NBR_NUM; i++)
        begin
            if (nb_ok[i] && is_tree(win.nbr[i]))
            begin
                tree_sum = tree_sum + fsa_pkg::NBR_CNT_W'(1);
            end
            if (nb_ok[i] && is_burning(win.nbr[i]))
            begin
                burn_sum = burn_sum + fsa_pkg::NBR_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (win_ready)
        begin
            s1_v_reg <= win_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_ready)
        begin
            s1_center_reg <= win.center;
            s1_tree_reg   <= tree_sum;
            s1_burn_reg   <= burn_sum;
            s1_draw_reg   <= win.draw;
            s1_end_reg    <= meta.frame_end;
        end
    end

    // Ignition tests: burning share above p_nbr percent, draw below p_catch percent
    always_comb
    begin
        burn_scaled  = NB_PROD_W'(s1_burn_reg) * NB_PROD_W'(fsa_pkg::PCT_SCALE);
        tree_scaled  = NB_PROD_W'(p_nbr) * NB_PROD_W'(s1_tree_reg);
        draw_scaled  = DRAW_PROD_W'(s1_draw_reg) * DRAW_PROD_W'(fsa_pkg::PCT_SCALE);
        catch_scaled = DRAW_PROD_W'({p_catch, {fsa_pkg::DRAW_W{1'b0}}});
        catches      = (s1_tree_reg != '0) && (burn_scaled > tree_scaled)
                       && (draw_scaled < catch_scaled);
        ign  = 1'b0;
        burn = 1'b0;
        unique case (s1_center_reg)
            fsa_pkg::CODE_TREE:
            begin
                next_code = catches ? fsa_pkg::CODE_BURN_A : fsa_pkg::CODE_TREE;
                ign       = catches;
            end
            fsa_pkg::CODE_FIRE:    next_code = fsa_pkg::CODE_BURN_A;
            fsa_pkg::CODE_BURN_A:  next_code = fsa_pkg::CODE_BURN_B;
            fsa_pkg::CODE_BURN_B:  next_code = fsa_pkg::CODE_BURN_C;
            fsa_pkg::CODE_BURN_C:
            begin
                next_code = fsa_pkg::CODE_BURNT;
                burn      = 1'b1;
            end
            fsa_pkg::CODE_BURNT:   next_code = fsa_pkg::CODE_BURNT;
            default:               next_code = fsa_pkg::CODE_EMPTY;
        endcase
        cnt_sum = cnt_reg + fsa_pkg::CNT_W'(ign) + fsa_pkg::CNT_W'(burn);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (restart)
        begin
            cnt_next = '0;
        end
        else if (s2_en && s1_v_reg)
        begin
            cnt_next = s1_end_reg ? '0 : cnt_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_v_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (s2_en)
            begin
                res_v_reg <= s1_v_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            res_reg.next_code     <= next_code;
            res_reg.ignited       <= ign;
            res_reg.burned_out    <= burn;
            res_reg.frame_end     <= s1_end_reg;
            res_reg.frame_changes <= s1_end_reg ? cnt_sum : '0;
        end
    end

    assign res_valid = res_v_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

### rtl/core/fsa_checker.sv
// Port-level checks for fire_spread_automaton_step_unit, attached by the bind below.
// Depends on fsa_pkg and on the top level's channel ports.
`timescale 1ns / 1ps
`default_nettype none

module fsa_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       res_valid,
    input wire logic                       res_ready,
    input wire logic [fsa_pkg::CODE_W-1:0] next_code,
    input wire logic                       ignited,
    input wire logic                       burned_out,
    input wire logic                       frame_end,
    input wire logic [fsa_pkg::CNT_W-1:0]  frame_changes
);

    // Stalled result item holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(next_code) && $stable(ignited)
                                    && $stable(burned_out) && $stable(frame_end)
                                    && $stable(frame_changes))
        else $error("result item changed while stalled");

    // Change count shows only on the frame's last item
    a_count_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !frame_end |-> frame_changes == '0)
        else $error("frame_changes nonzero before frame end");

    // Ignition lands on the first burn phase
    a_ignite_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && ignited |-> next_code == fsa_pkg::CODE_BURN_A && !burned_out)
        else $error("ignited item with wrong next code");

    // Burnout lands on burnt
    a_burnout_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && burned_out |-> next_code == fsa_pkg::CODE_BURNT)
        else $error("burned_out item with wrong next code");

endmodule

bind fire_spread_automaton_step_unit fsa_checker u_fsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (results.valid),
    .res_ready     (results.ready),
    .next_code     (results.next_code),
    .ignited       (results.ignited),
    .burned_out    (results.burned_out),
    .frame_end     (results.frame_end),
    .frame_changes (results.frame_changes)
);

`default_nettype wire
